>>> rtl/psls_pkg.sv
// shared constants, types and command/status structs for the prefix-sum search core
`default_nettype none
package psls_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int VAL_W = 32;
	localparam int POS_W = 11;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_EMIT_QUERY,
		ST_EMIT_FULL
	} state_t;

	typedef struct packed {
		logic load_en;
		logic search_start;
		logic search_step;
		logic emit_query;
		logic emit_full;
	} cmd_t;

	typedef struct packed {
		logic table_full;
		logic search_done;
		logic slot_free;
	} stat_t;

endpackage
`default_nettype wire

>>> rtl/psls_item_if.sv
// input channel: opcode and value with valid/ready
`default_nettype none
interface psls_item_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [31:0] value;

	modport source (output valid, output opcode, output value, input ready);
	modport sink (input valid, input opcode, input value, output ready);
endinterface
`default_nettype wire

>>> rtl/psls_result_if.sv
// output channel: position and table-full flag with valid/ready
`default_nettype none
interface psls_result_if;
	logic        valid;
	logic        ready;
	logic [10:0] position;
	logic        table_full;

	modport source (output valid, output position, output table_full, input ready);
	modport sink (input valid, input position, input table_full, output ready);
endinterface
`default_nettype wire

>>> rtl/prefix_sum_lower_bound_search_core.sv
// top level: prefix-sum table with lower-bound binary search
//
//  channel  dir  signals                      role
//  item     in   valid ready opcode value     load a segment length or query a key
//  result   out  valid ready position         one beat per query or refused load
//                table_full
//
// a load that is not refused gives no result beat
// a query makes one memory read per probe, the comparison folded into the
// next address
// the result sits in an output register, so a new item is taken while it waits
// reset clears the count and the running total; the table itself is not cleared
// a stalled result holds the controller only once its next result is ready
`default_nettype none
module prefix_sum_lower_bound_search_core (
	input  wire logic clk,
	input  wire logic arst_n,
	psls_item_if.sink     item,
	psls_result_if.source result
);
	import psls_pkg::*;

	cmd_t  cmd;
	stat_t stat;
	logic  in_ready;

	assign item.ready = in_ready;

	psls_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_opcode (item.opcode),
		.in_ready  (in_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	psls_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.value      (item.value),
		.cmd        (cmd),
		.stat       (stat),
		.out_ready  (result.ready),
		.out_valid  (result.valid),
		.position   (result.position),
		.table_full (result.table_full)
	);

endmodule
`default_nettype wire

>>> rtl/psls_ctrl.sv
// controller state machine: accepts beats, sequences the search, issues results
`default_nettype none
module psls_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire logic           in_opcode,
	output logic                in_ready,
	input  wire psls_pkg::stat_t stat,
	output psls_pkg::cmd_t      cmd
);
	import psls_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign accept = in_valid && (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (op_t'(in_opcode) == OP_QUERY) begin
						state_d = ST_SEARCH;
					end else if (stat.table_full) begin
						state_d = ST_EMIT_FULL;
					end
				end
			end
			ST_SEARCH: begin
				if (stat.search_done) begin
					state_d = ST_EMIT_QUERY;
				end
			end
			ST_EMIT_QUERY, ST_EMIT_FULL: begin
				if (stat.slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (accept) begin
					cmd.load_en      = (op_t'(in_opcode) == OP_LOAD) && !stat.table_full;
					cmd.search_start = (op_t'(in_opcode) == OP_QUERY);
				end
			end
			ST_SEARCH:     cmd.search_step = 1'b1;
			ST_EMIT_QUERY: cmd.emit_query  = stat.slot_free;
			ST_EMIT_FULL:  cmd.emit_full   = stat.slot_free;
			default: begin
				cmd      = '0;
				in_ready = 1'b0;
			end
		endcase
	end

endmodule
`default_nettype wire

>>> rtl/psls_dpath.sv
// datapath: prefix-sum memory, running total, search bounds and result register
`default_nettype none
module psls_dpath (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [psls_pkg::VAL_W-1:0]  value,
	input  wire psls_pkg::cmd_t              cmd,
	output psls_pkg::stat_t                  stat,
	input  wire logic                        out_ready,
	output logic                             out_valid,
	output logic [psls_pkg::POS_W-1:0]       position,
	output logic                             table_full
);
	import psls_pkg::*;

	logic [VAL_W-1:0] prefix_table [TABLE_DEPTH];

	logic [CNT_W-1:0] count_q;
	logic [VAL_W-1:0] total_q;
	logic [CNT_W-1:0] lo_q;
	logic [CNT_W-1:0] hi_q;
	logic [VAL_W-1:0] key_q;
	logic [VAL_W-1:0] rd_q;
	logic             pend_q;
	logic             out_valid_q;
	logic [POS_W-1:0] pos_q;
	logic             full_q;

	logic [VAL_W:0]   sum_wide;
	logic [VAL_W-1:0] sum_sat;
	logic [CNT_W-1:0] mid_c;
	logic [CNT_W-1:0] lo_n;
	logic [CNT_W-1:0] hi_n;
	logic [CNT_W-1:0] mid_n;
	logic             probe;

	// saturating add of the segment length
	assign sum_wide = {1'b0, total_q} + {1'b0, value};
	assign sum_sat  = sum_wide[VAL_W] ? '1 : sum_wide[VAL_W-1:0];

	// midpoint of the window that the pending read came from
	assign mid_c = lo_q + ((hi_q - lo_q) >> 1);

	// fold in the last probe, then pick the next midpoint
	always_comb begin
		lo_n = lo_q;
		hi_n = hi_q;
		if (pend_q) begin
			if (rd_q < key_q) begin
				lo_n = mid_c + CNT_W'(1);
			end else begin
				hi_n = mid_c;
			end
		end
	end

	assign mid_n = lo_n + ((hi_n - lo_n) >> 1);
	assign probe = lo_n < hi_n;

	always_comb begin
		stat             = '0;
		stat.table_full  = (count_q == CNT_W'(TABLE_DEPTH));
		stat.search_done = !probe;
		stat.slot_free   = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_en) begin
			prefix_table[count_q[IDX_W-1:0]] <= sum_sat;
		end
		if (cmd.search_step && probe) begin
			rd_q <= prefix_table[mid_n[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.search_start) begin
			lo_q  <= '0;
			hi_q  <= count_q;
			key_q <= value;
		end else if (cmd.search_step) begin
			lo_q <= lo_n;
			hi_q <= hi_n;
		end
		if (cmd.emit_query) begin
			pos_q  <= POS_W'({1'b0, lo_q} + {{CNT_W{1'b0}}, 1'b1});
			full_q <= 1'b0;
		end else if (cmd.emit_full) begin
			pos_q  <= '0;
			full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			total_q     <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_en) begin
				count_q <= count_q + CNT_W'(1);
				total_q <= sum_sat;
			end
			if (cmd.search_start) begin
				pend_q <= 1'b0;
			end else if (cmd.search_step) begin
				pend_q <= probe;
			end
			if (cmd.emit_query || cmd.emit_full) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign position   = pos_q;
	assign table_full = full_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_no_load_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_en |-> !stat.table_full)
		else $error("load written into a full table");

	a_emit_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_query || cmd.emit_full) |-> (!out_valid_q || out_ready))
		else $error("result overwrote a pending beat");

	a_probe_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (lo_q < hi_q) && (hi_q <= count_q))
		else $error("probe outside search window");

	a_emit_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_query || cmd.emit_full) |=> out_valid_q)
		else $error("result register not marked valid");

endmodule
`default_nettype wire
